>>> hdl/lmd_pkg.sv
package lmd_pkg;

  // operand and result width
  localparam int unsigned DATA_WIDTH = 32;
  // step counter width, indexes the DATA_WIDTH steps of one item
  localparam int unsigned CNT_W = $clog2(DATA_WIDTH);

  // operation codes, any other code acts as divide
  localparam logic [1:0] OP_MUL = 2'd0;
  localparam logic [1:0] OP_DIV = 2'd1;
  localparam logic [1:0] OP_MOD = 2'd2;

  // row controls from the sequencer
  typedef struct packed {
    logic load;  // take new operand words
    logic step;  // one shift-add or shift-subtract step
    logic div;   // divide or modulo, else multiply
  } lmd_row_ctl_t;

  // per-cell controls from the row
  typedef struct packed {
    logic load;
    logic step;
    logic sub;     // subtract the held operand bit
    logic commit;  // keep the sum, else keep the plain shifted bit
    logic add_en;  // add the held operand bit (multiply)
  } lmd_cell_ctl_t;

  // two's complement negate
  function automatic logic [DATA_WIDTH-1:0] neg_word(input logic [DATA_WIDTH-1:0] v);
    neg_word = (~v) + DATA_WIDTH'(1);
  endfunction

endpackage

>>> hdl/lmd_if.sv
interface lmd_in_if import lmd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [1:0]            operation;
  logic                  signed_mode;
  logic [DATA_WIDTH-1:0] left_operand;
  logic [DATA_WIDTH-1:0] right_operand;

  modport source (output valid, operation, signed_mode, left_operand, right_operand,
                  input ready);
  modport sink (input valid, operation, signed_mode, left_operand, right_operand,
                output ready);
endinterface

interface lmd_out_if import lmd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] result_value;
  logic                  divide_by_zero;

  modport source (output valid, result_value, divide_by_zero, input ready);
  modport sink (input valid, result_value, divide_by_zero, output ready);
endinterface

>>> hdl/lmd_cell.sv
module lmd_cell
  import lmd_pkg::*;
(
  input  logic          clk_i,
  input  lmd_cell_ctl_t ctl_i,
  input  logic          acc_ld_i,  // loaded into the accumulator on load, tied low by the row so it clears
  input  logic          q_ld_i,
  input  logic          d_ld_i,
  input  logic          acc_in_i,  // accumulator bit of the lower neighbor
  input  logic          q_in_i,    // shift bit of the lower neighbor
  input  logic          c_in_i,
  output logic          c_out_o,
  output logic          acc_o,
  output logic          q_o
);

  logic acc_q, q_q, d_q;
  logic x;
  logic sum;

  // operand bit for the full adder
  assign x       = ctl_i.sub ? ~d_q : (ctl_i.add_en & d_q);
  assign sum     = acc_in_i ^ x ^ c_in_i;
  assign c_out_o = (acc_in_i & x) | (c_in_i & (acc_in_i ^ x));

  // bit storage, one step per cycle while step is set
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      acc_q <= acc_ld_i;
      q_q   <= q_ld_i;
      d_q   <= d_ld_i;
    end else if (ctl_i.step) begin
      acc_q <= ctl_i.commit ? sum : acc_in_i;
      q_q   <= q_in_i;
    end
  end

  assign acc_o = acc_q;
  assign q_o   = q_q;

endmodule

>>> hdl/lmd_row.sv
module lmd_row
  import lmd_pkg::*;
(
  input  logic                  clk_i,
  input  lmd_row_ctl_t          ctl_i,
  input  logic [DATA_WIDTH-1:0] q_ld_i,
  input  logic [DATA_WIDTH-1:0] d_ld_i,
  output logic [DATA_WIDTH-1:0] acc_o,
  output logic [DATA_WIDTH-1:0] q_o
);

  logic [DATA_WIDTH:0]   carry;
  logic [DATA_WIDTH-1:0] acc, q;
  logic [DATA_WIDTH-1:0] acc_in, q_in;
  logic                  ge;
  lmd_cell_ctl_t         cell_ctl;

  // shifted remainder is at least the divisor
  assign ge = acc[DATA_WIDTH-1] | carry[DATA_WIDTH];

  // shared cell controls
  always_comb begin
    cell_ctl.load   = ctl_i.load;
    cell_ctl.step   = ctl_i.step;
    cell_ctl.sub    = ctl_i.div;
    cell_ctl.commit = ctl_i.div ? ge : 1'b1;
    cell_ctl.add_en = q[DATA_WIDTH-1];
  end

  // neighbor links: dividend bits move into the remainder, quotient bits enter below
  assign carry[0] = ctl_i.div;
  assign acc_in   = {acc[DATA_WIDTH-2:0], ctl_i.div & q[DATA_WIDTH-1]};
  assign q_in     = {q[DATA_WIDTH-2:0], ctl_i.div & ge};

  for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
    lmd_cell u_cell (
      .clk_i    (clk_i),
      .ctl_i    (cell_ctl),
      .acc_ld_i (1'b0),
      .q_ld_i   (q_ld_i[i]),
      .d_ld_i   (d_ld_i[i]),
      .acc_in_i (acc_in[i]),
      .q_in_i   (q_in[i]),
      .c_in_i   (carry[i]),
      .c_out_o  (carry[i+1]),
      .acc_o    (acc[i]),
      .q_o      (q[i])
    );
  end

  assign acc_o = acc;
  assign q_o   = q;

endmodule

>>> hdl/long_mul_div_mod_unit.sv
// Multiply, divide and modulo unit for DATA_WIDTH-bit operands.
// Input channel in_i carries operation, signed_mode and the two operands;
// output channel out_o carries result_value and divide_by_zero. An item is
// taken when valid and ready are both high.
// Multiply keeps the low word of the product, divide and modulo are
// restoring long division; in signed mode magnitudes are used and the
// product or quotient is negated when exactly one operand is negative.
// A zero divisor raises divide_by_zero, the quotient is all ones and the
// remainder is the dividend magnitude.
// From accept to result valid, the row of bit cells does one step per
// operand bit, its carry chain doing one shift-add or shift-subtract per
// cycle, and then the sign fix-up goes into the output register. One item
// is in work at a time: a new item is taken only after the result has
// been written to the output register.
// The output register holds the result until it is taken; the next item is
// accepted meanwhile, and its fix-up waits while the old result stalls.
// Reset returns to idle with no result pending; in_i.ready is high after.
module long_mul_div_mod_unit
  import lmd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  lmd_in_if.sink    in_i,
  lmd_out_if.source out_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_e;

  state_e                state_q;
  logic [CNT_W-1:0]      cnt_q;
  logic                  is_mul_q, is_mod_q, neg_q, dz_q;
  logic                  out_valid_q, out_dz_q;
  logic [DATA_WIDTH-1:0] out_res_q;

  logic                  in_acc, out_free;
  logic                  a_neg, b_neg, in_mul, in_div;
  logic [DATA_WIDTH-1:0] a_mag, b_mag, res_d;
  logic [DATA_WIDTH-1:0] acc, q;
  lmd_row_ctl_t          row_ctl;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid & in_i.ready;
  assign out_free   = ~out_valid_q | out_o.ready;

  // operand magnitudes
  assign a_neg  = in_i.signed_mode & in_i.left_operand[DATA_WIDTH-1];
  assign b_neg  = in_i.signed_mode & in_i.right_operand[DATA_WIDTH-1];
  assign a_mag  = a_neg ? neg_word(in_i.left_operand) : in_i.left_operand;
  assign b_mag  = b_neg ? neg_word(in_i.right_operand) : in_i.right_operand;
  assign in_mul = (in_i.operation == OP_MUL);
  assign in_div = ~in_mul;

  // row controls
  always_comb begin
    row_ctl.load = in_acc;
    row_ctl.step = (state_q == S_RUN);
    row_ctl.div  = ~is_mul_q;
  end

  lmd_row u_row (
    .clk_i  (clk_i),
    .ctl_i  (row_ctl),
    .q_ld_i (in_mul ? b_mag : a_mag),
    .d_ld_i (in_mul ? a_mag : b_mag),
    .acc_o  (acc),
    .q_o    (q)
  );

  // sign fix-up and zero divisor result
  always_comb begin
    if (is_mul_q) begin
      res_d = neg_q ? neg_word(acc) : acc;
    end else if (is_mod_q) begin
      res_d = acc;
    end else if (dz_q) begin
      res_d = '1;
    end else begin
      res_d = neg_q ? neg_word(q) : q;
    end
  end

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      is_mul_q    <= 1'b0;
      is_mod_q    <= 1'b0;
      neg_q       <= 1'b0;
      dz_q        <= 1'b0;
      out_valid_q <= 1'b0;
      out_dz_q    <= 1'b0;
      out_res_q   <= '0;
    end else begin
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            state_q  <= S_RUN;
            cnt_q    <= '0;
            is_mul_q <= in_mul;
            is_mod_q <= (in_i.operation == OP_MOD);
            neg_q    <= a_neg ^ b_neg;
            dz_q     <= in_div && (in_i.right_operand == '0);
          end
        end
        S_RUN: begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_W'(DATA_WIDTH - 1)) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_res_q   <= res_d;
            out_dz_q    <= dz_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.result_value   = out_res_q;
  assign out_o.divide_by_zero = out_dz_q;

endmodule

>>> hdl/lmd_check.sv
module lmd_check
  import lmd_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic [DATA_WIDTH-1:0] out_result_i,
  input logic                  out_dz_i
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_result_i) && $stable(out_dz_i))
    else $error("stalled result changed");

  // one item in work at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while busy");

  // a new result follows a full run of steps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i, 1) && !$past(in_ready_i, DATA_WIDTH))
    else $error("result without a full run");

endmodule

bind long_mul_div_mod_unit lmd_check u_lmd_check (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_result_i (out_o.result_value),
  .out_dz_i     (out_o.divide_by_zero)
);
